FILE: sv/csu_pkg.sv
// Package for the counting semaphore unit: operation and status codes,
// controller state encoding and the result record. No dependencies.
package csu_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WAKE = 4'b0100,
    S_HOLD = 4'b1000
  } fsm_t;

  localparam int unsigned ID_W  = 6;
  localparam int unsigned PID_W = 6;
  localparam int unsigned CNT_W = 16;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   alloc_id;
    logic              caller_blocked;
    logic              woken_valid;
    logic [PID_W-1:0]  woken_pid;
  } result_t;

endpackage

FILE: sv/counting_semaphore_unit.sv
// Counting semaphore bank with a FIFO wait queue per semaphore.
// Depends on csu_pkg; holds the slot state memory and the wait queue memory.
//
//  channel  | dir | tuser        | tdata
//  s_axis   | in  | op           | sem_id, init_count, caller_pid
//  m_axis   | out | status       | alloc_id, caller_blocked, woken_valid, woken_pid
//
// Allocate, wait and free go from the request and state memory read registers to exec;
// a signal that wakes a waiter adds a wake state, since its head pointer comes out of
// the state memory before the queue memory can be read.
// rst clears the slot in-use bits, the controller and the output valid; the
// memories need no clearing. A stalled output holds its item; the next item is
// still taken while it waits, and the controller holds a finished result.
module counting_semaphore_unit #(
  parameter int unsigned NUM_SEMAPHORES = 64,
  parameter int unsigned QUEUE_DEPTH    = 64,
  parameter int unsigned PID_WIDTH      = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sem_id[5:0], init_count[21:6], caller_pid[27:22]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // alloc_id[5:0], caller_blocked[6], woken_valid[7],
                                      // woken_pid[13:8]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import csu_pkg::*;

  localparam int unsigned SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AS = (NUM_SEMAPHORES < 64) ? NUM_SEMAPHORES : 64;
  localparam int unsigned GN = (AS + 7) / 8;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic [HW-1:0]           head;
    logic [LW-1:0]           length;
  } sem_rec_t;

  // input unpack
  op_t                      in_op;
  logic [ID_W-1:0]          in_id;
  logic [PID_W-1:0]         in_pid;
  logic [PID_W+7:0]         pid_ext;
  logic                     accept;

  // request registers
  op_t                      req_op;
  logic                     req_id_ok;
  logic [SW-1:0]            req_slot;
  logic signed [CNT_W-1:0]  req_init;
  logic [PID_WIDTH-1:0]     req_pid;

  // memories
  sem_rec_t                 st_mem [NUM_SEMAPHORES];
  sem_rec_t                 st_rd;
  logic                     st_we;
  sem_rec_t                 st_wdata;
  logic [SW-1:0]            st_waddr;
  logic [PID_WIDTH-1:0]     q_mem [NUM_SEMAPHORES][QUEUE_DEPTH];
  logic [PID_WIDTH-1:0]     q_rd;
  logic                     q_we;
  logic                     q_re;
  logic [HW-1:0]            q_idx;
  logic [PID_WIDTH+5:0]     wpid_ext;

  logic [NUM_SEMAPHORES-1:0] slot_in_use;

  // free slot search, first level registered at accept
  logic [GN*8-1:0]          free_vec;
  logic [GN-1:0]            grp_any_c, grp_any;
  logic [2:0]               grp_idx_c [GN];
  logic [2:0]               grp_idx   [GN];
  logic                     found;
  logic [ID_W-1:0]          found_id;

  fsm_t                     state, state_next;
  result_t                  res, res_next;
  logic                     out_free;
  logic                     wake;
  logic                     set_slot, clr_slot;
  logic [SW-1:0]            set_idx;

  // exec datapath
  logic                     slot_valid;
  logic signed [CNT_W:0]    dec;
  logic signed [CNT_W-1:0]  inc;
  logic [HW:0]              tail_sum;

  assign in_op   = op_t'(s_axis_tuser);
  assign in_id   = s_axis_tdata[5:0];
  assign in_pid  = s_axis_tdata[27:22];
  assign pid_ext = {8'b0, in_pid};
  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= in_op;
      req_id_ok <= ({{(32-ID_W){1'b0}}, in_id} < NUM_SEMAPHORES);
      req_slot  <= SW'(in_id);
      req_init  <= s_axis_tdata[21:6];
      req_pid   <= pid_ext[PID_WIDTH-1:0];
      grp_any   <= grp_any_c;
      grp_idx   <= grp_idx_c;
    end
  end

  // state memory: read at accept, write back in exec
  always_ff @(posedge clk) begin
    if (accept) begin
      st_rd <= st_mem[SW'(in_id)];
    end
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
  end

  // wait queue memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[req_slot][q_idx] <= req_pid;
    end
    if (q_re) begin
      q_rd <= q_mem[req_slot][q_idx];
    end
  end

  always_comb begin
    free_vec = '0;
    for (int k = 0; k < GN * 8; k++) begin
      if (k < AS) begin
        free_vec[k] = !slot_in_use[k];
      end
    end
    for (int g = 0; g < GN; g++) begin
      grp_any_c[g] = 1'b0;
      grp_idx_c[g] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (free_vec[g*8+j]) begin
          grp_any_c[g] = 1'b1;
          grp_idx_c[g] = 3'(j);
        end
      end
    end
  end

  always_comb begin
    found    = 1'b0;
    found_id = '0;
    for (int g = GN - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found    = 1'b1;
        found_id = {3'(g), grp_idx[g]};
      end
    end
  end

  assign slot_valid = req_id_ok && slot_in_use[req_slot];
  assign dec        = {st_rd.count[CNT_W-1], st_rd.count} - (CNT_W+1)'(1);
  assign inc        = (st_rd.count != 16'sh7fff) ? st_rd.count + 16'sd1 : st_rd.count;
  assign tail_sum   = {1'b0, st_rd.head} + (HW+1)'(st_rd.length);
  assign set_idx    = SW'(found_id);

  always_comb begin
    state_next = state;
    res_next   = '{status: ST_DONE, alloc_id: '0, caller_blocked: 1'b0,
                   woken_valid: 1'b0, woken_pid: '0};
    st_we      = 1'b0;
    st_waddr   = req_slot;
    st_wdata   = st_rd;
    q_we       = 1'b0;
    q_re       = 1'b0;
    q_idx      = st_rd.head;
    wake       = 1'b0;
    set_slot   = 1'b0;
    clr_slot   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_op)
          OP_ALLOC: begin
            res_next.status = ST_FAIL;
            if (!req_init[CNT_W-1] && req_init != '0 && found) begin
              set_slot          = 1'b1;
              st_we             = 1'b1;
              st_waddr          = set_idx;
              st_wdata          = '{count: req_init, head: '0, length: '0};
              res_next.status   = ST_DONE;
              res_next.alloc_id = found_id;
            end
          end
          OP_WAIT: begin
            if (!slot_valid) begin
              res_next.status = ST_FAIL;
            end else if (dec[CNT_W]) begin
              if (st_rd.length >= LW'(QUEUE_DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                // tail wraps at most once
                q_idx = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                        HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
                q_we            = 1'b1;
                st_we           = 1'b1;
                st_wdata.count  = dec[CNT_W-1:0];
                st_wdata.length = st_rd.length + LW'(1);
                res_next.caller_blocked = 1'b1;
              end
            end else begin
              st_we          = 1'b1;
              st_wdata.count = dec[CNT_W-1:0];
            end
          end
          OP_SIGNAL: begin
            if (!slot_valid) begin
              res_next.status = ST_FAIL;
            end else begin
              st_we          = 1'b1;
              st_wdata.count = inc;
              if ((inc[CNT_W-1] || inc == '0) && st_rd.length != '0) begin
                wake = 1'b1;
                q_re = 1'b1;
                st_wdata.head = (st_rd.head == HW'(QUEUE_DEPTH - 1)) ?
                                '0 : st_rd.head + HW'(1);
                st_wdata.length = st_rd.length - LW'(1);
              end
            end
          end
          OP_FREE: begin
            if (!slot_valid) begin
              res_next.status = ST_FAIL;
            end else begin
              clr_slot = 1'b1;
            end
          end
          default: begin
            res_next.status = ST_FAIL;
          end
        endcase
        if (wake) begin
          state_next = S_WAKE;
        end else if (out_free) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_WAKE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign wpid_ext = {6'b0, q_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_in_use   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (set_slot) begin
        slot_in_use[set_idx] <= 1'b1;
      end
      if (clr_slot) begin
        slot_in_use[req_slot] <= 1'b0;
      end
      if (out_free && ((state == S_EXEC && !wake) || state == S_WAKE ||
                       state == S_HOLD)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the finished result; load the output stage once it frees up
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res <= res_next;
    end
    if (out_free) begin
      case (state)
        S_EXEC: begin
          m_axis_tuser <= res_next.status;
          m_axis_tdata <= {2'b0, res_next.woken_pid, res_next.woken_valid,
                           res_next.caller_blocked, res_next.alloc_id};
        end
        S_WAKE: begin
          m_axis_tuser <= ST_DONE;
          m_axis_tdata <= {2'b0, wpid_ext[5:0], 1'b1, 1'b0, 6'b0};
        end
        S_HOLD: begin
          m_axis_tuser <= res.status;
          m_axis_tdata <= {2'b0, res.woken_pid, res.woken_valid,
                           res.caller_blocked, res.alloc_id};
        end
        default: begin
        end
      endcase
    end
  end

endmodule
